FILE: rtl/b64d_pkg.sv
// Shared types, constants and the character decode function of the Base64 decoder.
package b64d_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_PAD  = 2'd2,
    ST_BAD_LEN  = 2'd3
  } b64d_status_t;

  // Classification of one input character.
  typedef struct packed {
    logic       is_data;
    logic       is_pad;
    logic [5:0] value;
  } b64d_sym_t;

  // Work handed from the front to the back: up to three bytes of one group,
  // plus the end-of-run mark and its status.
  typedef struct packed {
    logic [23:0]  word;
    logic [1:0]   cnt;
    logic         fin;
    b64d_status_t status;
  } b64d_job_t;

  function automatic b64d_sym_t classify_char(input logic [7:0] c);
    b64d_sym_t sym;
    sym.is_data = 1'b0;
    sym.is_pad  = 1'b0;
    sym.value   = 6'd0;
    case (c) inside
      [8'h41:8'h5A]: begin
        sym.is_data = 1'b1;
        sym.value   = 6'(c - 8'h41);
      end
      [8'h61:8'h7A]: begin
        sym.is_data = 1'b1;
        sym.value   = 6'(c - 8'h61 + 8'd26);
      end
      [8'h30:8'h39]: begin
        sym.is_data = 1'b1;
        sym.value   = 6'(c - 8'h30 + 8'd52);
      end
      8'h2B: begin
        sym.is_data = 1'b1;
        sym.value   = 6'd62;
      end
      8'h2F: begin
        sym.is_data = 1'b1;
        sym.value   = 6'd63;
      end
      8'h3D: begin
        sym.is_pad = 1'b1;
      end
      default: begin
        sym.is_data = 1'b0;
      end
    endcase
    return sym;
  endfunction

endpackage

FILE: rtl/b64d_if.sv
// Valid/ready stream interfaces for encoded characters and decoded results.
interface b64d_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       final_char;

  modport source (output valid, in_char, final_char, input ready);
  modport sink (input valid, in_char, final_char, output ready);
  modport mon (input valid, ready, in_char, final_char);
endinterface

interface b64d_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       end_of_run;

  modport source (output valid, data_byte, byte_valid, status, end_of_run, input ready);
  modport sink (input valid, data_byte, byte_valid, status, end_of_run, output ready);
  modport mon (input valid, ready, data_byte, byte_valid, status, end_of_run);
endinterface

FILE: rtl/b64d_front.sv
// Front end: accepts characters, tracks group and padding state, and builds jobs.
module b64d_front (
  input  logic              clk,
  input  logic              rst,
  b64d_in_if.sink           enc,
  input  logic              q_not_full,
  output logic              push,
  output b64d_pkg::b64d_job_t push_job
);

  logic [1:0]             pos;
  logic [1:0]             pos_next;
  logic [17:0]            store;
  logic [17:0]            store_next;
  logic [1:0]             pad_count;
  logic [1:0]             pad_count_next;
  logic                   pad_done;
  logic                   pad_done_next;
  b64d_pkg::b64d_status_t err;
  b64d_pkg::b64d_status_t err_next;
  b64d_pkg::b64d_sym_t    sym;
  logic [5:0]             v;
  logic [1:0]             pad_inc;
  logic                   fire;

  assign enc.ready = q_not_full;
  assign fire      = enc.valid && enc.ready;

  always_comb begin
    sym            = b64d_pkg::classify_char(enc.in_char);
    v              = sym.is_pad ? 6'd0 : sym.value;
    pad_inc        = pad_count + {1'b0, sym.is_pad};
    pos_next       = pos;
    store_next     = store;
    pad_count_next = pad_count;
    pad_done_next  = pad_done;
    err_next       = err;
    push_job.word   = 24'd0;
    push_job.cnt    = 2'd0;
    push_job.fin    = enc.final_char;
    push_job.status = b64d_pkg::ST_OK;

    if (err == b64d_pkg::ST_OK) begin
      if (!sym.is_data && !sym.is_pad) begin
        err_next = b64d_pkg::ST_BAD_CHAR;
      end else if (pad_done) begin
        err_next = b64d_pkg::ST_BAD_PAD;
      end else if (sym.is_pad && !pos[1]) begin
        err_next = b64d_pkg::ST_BAD_PAD;
      end else if (!sym.is_pad && pad_count != 2'd0) begin
        err_next = b64d_pkg::ST_BAD_PAD;
      end else if (pos != 2'd3) begin
        store_next     = {store[11:0], v};
        pos_next       = pos + 2'd1;
        pad_count_next = pad_inc;
      end else begin
        push_job.word  = {store, v};
        case (pad_inc)
          2'd0:    push_job.cnt = 2'd3;
          2'd1:    push_job.cnt = 2'd2;
          default: push_job.cnt = 2'd1;
        endcase
        pad_done_next  = (pad_inc != 2'd0);
        pos_next       = 2'd0;
        store_next     = 18'd0;
        pad_count_next = 2'd0;
      end
    end

    // The length check applies only to a run that is otherwise clean.
    if (err_next == b64d_pkg::ST_OK && pos_next != 2'd0) begin
      push_job.status = enc.final_char ? b64d_pkg::ST_BAD_LEN : b64d_pkg::ST_OK;
    end else begin
      push_job.status = enc.final_char ? err_next : b64d_pkg::ST_OK;
    end

    push = fire && (push_job.cnt != 2'd0 || enc.final_char);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 2'd0;
      store     <= 18'd0;
      pad_count <= 2'd0;
      pad_done  <= 1'b0;
      err       <= b64d_pkg::ST_OK;
    end else if (fire) begin
      if (enc.final_char) begin
        pos       <= 2'd0;
        store     <= 18'd0;
        pad_count <= 2'd0;
        pad_done  <= 1'b0;
        err       <= b64d_pkg::ST_OK;
      end else begin
        pos       <= pos_next;
        store     <= store_next;
        pad_count <= pad_count_next;
        pad_done  <= pad_done_next;
        err       <= err_next;
      end
    end
  end

endmodule

FILE: rtl/b64d_queue.sv
// Small job queue between the front end and the byte emitter.
module b64d_queue #(
  parameter int Depth = b64d_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64d_pkg::b64d_job_t push_job,
  input  logic                pop,
  output b64d_pkg::b64d_job_t head,
  output logic                not_empty,
  output logic                not_full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  b64d_pkg::b64d_job_t mem [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != CntW'(0));
  assign not_full  = (count != CntW'(Depth));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/b64d_back.sv
// Back end: takes jobs from the queue and emits one result per transfer.
module b64d_back (
  input  logic                clk,
  input  logic                rst,
  input  b64d_pkg::b64d_job_t head,
  input  logic                q_not_empty,
  output logic                pop,
  b64d_out_if.source          dec
);

  b64d_pkg::b64d_job_t cur;
  logic                cur_valid;
  logic [1:0]          idx;
  logic                last;
  logic                done;
  logic [7:0]          sel_byte;

  always_comb begin
    last = (cur.cnt == 2'd0) || (idx == cur.cnt - 2'd1);
    done = !cur_valid || (dec.ready && last);
    pop  = done && q_not_empty;
    case (idx)
      2'd0:    sel_byte = cur.word[23:16];
      2'd1:    sel_byte = cur.word[15:8];
      default: sel_byte = cur.word[7:0];
    endcase
    dec.valid      = cur_valid;
    dec.byte_valid = (cur.cnt != 2'd0);
    dec.data_byte  = (cur.cnt != 2'd0) ? sel_byte : 8'd0;
    dec.end_of_run = cur.fin && last;
    dec.status     = (cur.fin && last) ? cur.status : b64d_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= q_not_empty;
      idx       <= 2'd0;
    end else if (dec.ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

FILE: rtl/base64_stream_decoder.sv
// Streaming Base64 decoder: one character in per cycle, one byte or status result out per cycle.
// Path: a finished group is written into the job queue, then loaded into the emitter register.
// Throughput: one character accepted per cycle while the job queue has room; one result leaves
// per cycle while dec.ready is high, limited by the single output register of the byte emitter.
// Reset (rst, synchronous, active high) empties the queue and clears all group state.
// Top level: wires the front end, the job queue and the byte emitter together.
module base64_stream_decoder #(
  parameter int QueueDepth = b64d_pkg::QUEUE_DEPTH
) (
  input logic      clk,
  input logic      rst,
  b64d_in_if.sink  enc,
  b64d_out_if.source dec
);

  logic                push;
  b64d_pkg::b64d_job_t push_job;
  logic                pop;
  b64d_pkg::b64d_job_t head;
  logic                q_not_empty;
  logic                q_not_full;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enc        (enc),
    .q_not_full (q_not_full),
    .push       (push),
    .push_job   (push_job)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .dec         (dec)
  );

endmodule

FILE: rtl/b64d_checker.sv
// Port-level checks of the decoder, attached to the top level by bind.
module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [7:0] data_byte,
  input logic       byte_valid,
  input logic [1:0] status,
  input logic       end_of_run
);

  // Nothing is offered right after reset, since the queue and emitter start empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("result offered right after reset");

  // A result without a byte exists only to carry the end of the run.
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    valid && !byte_valid |-> end_of_run)
    else $error("byteless result without end_of_run");

  // A non-ok status appears only on the end of the run.
  a_status_at_end: assert property (@(posedge clk) disable iff (rst)
    valid && status != b64d_pkg::ST_OK |-> end_of_run)
    else $error("status set before end of run");

  // A byteless result carries a zero data byte.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !byte_valid |-> data_byte == 8'd0)
    else $error("data byte not zero on byteless result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(data_byte)
      && $stable(byte_valid) && $stable(status) && $stable(end_of_run))
    else $error("stalled result changed");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (dec.valid),
  .ready      (dec.ready),
  .data_byte  (dec.data_byte),
  .byte_valid (dec.byte_valid),
  .status     (dec.status),
  .end_of_run (dec.end_of_run)
);
